FILE: rtl/core/tcw_pkg.sv
// Shared types, codes and constants of the text console cell writer.
package tcw_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STOP_DEF = 4;

  localparam int CELL_W = 16;

  // Character codes with special handling
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [3:0] WHITE_FG = 4'hF;

  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_SET     = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_RECOLOR = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [7:0] col;
    logic [7:0] row;
  } item_t;

  typedef struct packed {
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic [10:0] cur_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } result_t;

  // Cursor command from the sequencer
  typedef struct packed {
    logic       put;
    logic       set;
    logic       home;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } cur_cmd_t;

  // What a put-character step asks of the store
  typedef struct packed {
    logic wr;
    logic space;
    logic scroll;
  } put_ev_t;

  // Column remainder modulo the tab stop, for every 8-bit column
  function automatic logic [255:0][2:0] tab_rem_table(input int tab);
    logic [255:0][2:0] t;
    int r;
    r = 0;
    for (int i = 0; i < 256; i++) begin
      t[i] = 3'(r);
      r = (r + 1 == tab) ? 0 : r + 1;
    end
    return t;
  endfunction

endpackage

FILE: rtl/core/tcw_screen_ram.sv
// Screen cell store: one write port and one registered read port.
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH = COLUMNS_DEF * ROWS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [CELL_W-1:0]        wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [CELL_W-1:0]        rd
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

FILE: rtl/core/tcw_cursor.sv
// Cursor registers and the put-character / set-cursor update logic.
module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cur_cmd_t                            cmd,
  output logic [$clog2(COLUMNS)-1:0]          col,
  output logic [$clog2(ROWS)-1:0]             row,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     idx,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     wr_addr,
  output put_ev_t                             ev,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     pos_idx,
  output logic                                pos_ok
);

  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);
  localparam int IDX_W    = $clog2(COLUMNS * ROWS);
  localparam int LAST_ROW = (ROWS - 1) * COLUMNS;
  localparam logic [255:0][2:0] TAB_REM = tab_rem_table(TAB_STOP);

  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [IDX_W-1:0] idx_next;
  logic             nl;
  logic [3:0]       tab_step;
  logic [8:0]       tab_col;

  assign pos_ok  = (9'(cmd.col) < 9'(COLUMNS)) && (9'(cmd.row) < 9'(ROWS));
  assign pos_idx = IDX_W'(IDX_W'(cmd.row[ROW_W-1:0]) * IDX_W'(COLUMNS)) + IDX_W'(cmd.col);

  assign tab_step = 4'(TAB_STOP) - 4'(TAB_REM[8'(col)]);
  assign tab_col  = 9'(col) + 9'(tab_step);

  always_comb begin
    col_next = col;
    row_next = row;
    idx_next = idx;
    wr_addr  = idx;
    ev       = '0;
    nl       = 1'b0;
    if (cmd.home) begin
      col_next = '0;
      row_next = '0;
      idx_next = '0;
    end else if (cmd.set) begin
      if (pos_ok) begin
        col_next = COL_W'(cmd.col);
        row_next = ROW_W'(cmd.row);
        idx_next = pos_idx;
      end
    end else if (cmd.put) begin
      case (cmd.ch)
        CH_NL: begin
          nl = 1'b1;
        end
        CH_CR: begin
          col_next = '0;
          idx_next = idx - IDX_W'(col);
        end
        CH_BS: begin
          ev.wr    = 1'b1;
          ev.space = 1'b1;
          // stepping back across a row edge is still one cell back in linear order
          if (col != '0) begin
            col_next = col - 1'b1;
            idx_next = idx - 1'b1;
            wr_addr  = idx - 1'b1;
          end else if (row != '0) begin
            row_next = row - 1'b1;
            col_next = COL_W'(COLUMNS - 1);
            idx_next = idx - 1'b1;
            wr_addr  = idx - 1'b1;
          end
        end
        CH_TAB: begin
          if (tab_col >= 9'(COLUMNS)) begin
            nl = 1'b1;
          end else begin
            col_next = COL_W'(tab_col);
            idx_next = idx + IDX_W'(tab_step);
          end
        end
        default: begin
          ev.wr = 1'b1;
          if (col == COL_W'(COLUMNS - 1)) begin
            nl = 1'b1;
          end else begin
            col_next = col + 1'b1;
            idx_next = idx + 1'b1;
          end
        end
      endcase
      if (nl) begin
        col_next = '0;
        if (row == ROW_W'(ROWS - 1)) begin
          ev.scroll = 1'b1;
          idx_next  = IDX_W'(LAST_ROW);
        end else begin
          row_next = row + 1'b1;
          idx_next = idx - IDX_W'(col) + IDX_W'(COLUMNS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      idx <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
      idx <= idx_next;
    end
  end

endmodule

FILE: rtl/core/text_console_cell_writer.sv
// Text console cell writer top level: command sequencer and store sweep unit.
//
// Usage: present a word on item and raise start while busy is low; the word
// is taken at that clock edge. busy stays high until the result word has been
// shown. The result word (cursor after the command, its linear offset, and
// for a read the cell contents) appears on result for exactly one cycle with
// done high; the receiver cannot stall it and must take it then.
// Configuration: cfg_data carries the background color nibble, written when
// cfg_valid and cfg_ready are both high; cfg_ready is always high. Write it
// only while the block is idle.
// Path from the accepting edge: every command passes an execute state and
// then the done state. An in-range read cell adds one registered store read
// between them, a put char that scrolls adds a copy sweep of the store one
// row up and a fill of the bottom row, clear adds a fill of the whole store,
// and recolor adds a copy sweep. A new word is taken only after done; busy
// is low the cycle after done. The sweeps are set by the single store port
// pair: one cell per cycle.
// Reset: the cursor and background go to zero and a clearing pass writes
// zero to all ROWS*COLUMNS cells, one per cycle, with busy high throughout.
module text_console_cell_writer import tcw_pkg::*; #(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STOP = TAB_STOP_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  item_t   item,
  output logic    busy,
  output logic    done,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic [3:0] cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int PTR_W      = $clog2(CELL_COUNT + 1);

  state_t state, state_next;

  // sweep pointer and the delayed write address of a copy sweep
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [IDX_W-1:0] wa, wa_next;
  logic             pend, pend_next;
  logic             scroll, scroll_next;

  item_t            job, job_next;
  logic [3:0]       bg;
  logic [7:0]       cell_char, cell_char_next;
  logic [7:0]       cell_attr, cell_attr_next;

  // store port
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [IDX_W-1:0]  mem_ra;
  logic [CELL_W-1:0] mem_rd;

  // cursor unit
  cur_cmd_t         cmd;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] put_addr;
  put_ev_t          ev;
  logic [IDX_W-1:0] pos_idx;
  logic             pos_ok;

  logic [PTR_W-1:0]  copy_end;
  logic [CELL_W-1:0] blank;

  assign copy_end = scroll ? PTR_W'(MOVE_COUNT) : PTR_W'(CELL_COUNT);
  assign blank    = {bg, WHITE_FG, CH_SPACE};

  tcw_screen_ram #(
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk(clk),
    .we (mem_we),
    .wa (mem_wa),
    .wd (mem_wd),
    .ra (mem_ra),
    .rd (mem_rd)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_cursor (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .col    (cur_col),
    .row    (cur_row),
    .idx    (cur_idx),
    .wr_addr(put_addr),
    .ev     (ev),
    .pos_idx(pos_idx),
    .pos_ok (pos_ok)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (ptr == PTR_W'(CELL_COUNT - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (opcode_t'(job.opcode))
          OP_PUT:     state_next = ev.scroll ? ST_COPY : ST_DONE;
          OP_CLEAR:   state_next = ST_FILL;
          OP_RECOLOR: state_next = ST_COPY;
          OP_READ:    state_next = pos_ok ? ST_READ : ST_DONE;
          default:    state_next = ST_DONE;
        endcase
      end
      ST_COPY: begin
        // last pending write lands this cycle
        if (ptr == copy_end) begin
          state_next = scroll ? ST_FILL : ST_DONE;
        end
      end
      ST_FILL: begin
        if (ptr == PTR_W'(CELL_COUNT - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: store port, cursor command, handshake
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = ptr[IDX_W-1:0];
    mem_wd   = blank;
    mem_ra   = '0;
    cmd      = '0;
    cmd.ch   = job.char_code;
    cmd.col  = job.col;
    cmd.row  = job.row;
    busy     = (state != ST_IDLE);
    done     = (state == ST_DONE);
    case (state)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      ST_EXEC: begin
        cmd.put  = (opcode_t'(job.opcode) == OP_PUT);
        cmd.set  = (opcode_t'(job.opcode) == OP_SET);
        cmd.home = (opcode_t'(job.opcode) == OP_CLEAR);
        mem_ra   = pos_idx;
        if (cmd.put && ev.wr) begin
          mem_we = 1'b1;
          mem_wa = put_addr;
          mem_wd = {bg, job.fg_color, ev.space ? CH_SPACE : job.char_code};
        end
      end
      ST_COPY: begin
        // read ahead of the write; scroll reads one row further down
        if (ptr != copy_end) begin
          mem_ra = IDX_W'(ptr + (scroll ? PTR_W'(COLUMNS) : PTR_W'(0)));
        end
        mem_we = pend;
        mem_wa = wa;
        mem_wd = scroll ? mem_rd : {bg, job.fg_color, mem_rd[7:0]};
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    ptr_next       = ptr;
    wa_next        = wa;
    pend_next      = pend;
    scroll_next    = scroll;
    job_next       = job;
    cell_char_next = cell_char;
    cell_attr_next = cell_attr;
    case (state)
      ST_INIT: begin
        ptr_next = (ptr == PTR_W'(CELL_COUNT - 1)) ? '0 : ptr + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          job_next = item;
        end
      end
      ST_EXEC: begin
        cell_char_next = '0;
        cell_attr_next = '0;
        ptr_next       = '0;
        pend_next      = 1'b0;
        scroll_next    = (opcode_t'(job.opcode) == OP_PUT);
      end
      ST_COPY: begin
        if (ptr != copy_end) begin
          ptr_next  = ptr + 1'b1;
          wa_next   = ptr[IDX_W-1:0];
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      ST_FILL: begin
        ptr_next = ptr + 1'b1;
      end
      ST_READ: begin
        cell_char_next = mem_rd[7:0];
        cell_attr_next = mem_rd[15:8];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      ptr   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      pend  <= pend_next;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    wa        <= wa_next;
    scroll    <= scroll_next;
    job       <= job_next;
    cell_char <= cell_char_next;
    cell_attr <= cell_attr_next;
  end

  // Background color register; always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      bg <= cfg_data;
    end
  end

  // Result word, masked to the port widths
  always_comb begin
    result.cur_col    = 7'(cur_col);
    result.cur_row    = 5'(cur_row);
    result.cur_offset = 11'(cur_idx);
    result.cell_char  = cell_char;
    result.cell_attr  = cell_attr;
  end

endmodule

FILE: test/text_console_cell_writer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the text console cell writer: directed table, then random words.
module text_console_cell_writer_tb;
  import tcw_pkg::*;

  // Geometry of the instance under test (package defaults)
  localparam int COLS  = COLUMNS_DEF;
  localparam int ROWS  = ROWS_DEF;
  localparam int TAB   = TAB_STOP_DEF;
  localparam int CELLS = COLS * ROWS;

  // Opcodes the block decodes to nothing
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Control characters for the random text mix
  localparam logic [3:0][7:0] CONTROL_CHARS = {CH_NL, CH_CR, CH_BS, CH_TAB};

  localparam int WORDS_PER_PHASE = 450;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  item_t      item;
  logic       busy;
  logic       done;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  text_console_cell_writer dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow console: screen store, cursor and background of the block
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_cells [CELLS];
  int          shadow_col;
  int          shadow_row;
  logic [3:0]  shadow_bg;

  result_t pending_results [$];
  int      errors = 0;

  // Build one screen cell: attribute byte is background over foreground
  function automatic logic [15:0] cell_word(logic [7:0] ch, logic [3:0] fg);
    return {shadow_bg, fg, ch};
  endfunction

  // Drop to the start of the next row; past the bottom, scroll the store up
  // one row and blank the bottom row in white on the background.
  function automatic void next_line();
    shadow_col = 0;
    shadow_row++;
    if (shadow_row >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++)
        shadow_cells[i] = cell_word(CH_SPACE, WHITE_FG);
      shadow_row = ROWS - 1;
    end
  endfunction

  // Apply one command word to the shadow console and return the result word
  function automatic result_t console_step(item_t w);
    result_t r;
    r = '0;
    case (w.opcode)
      OP_PUT: begin
        case (w.char_code)
          CH_NL: next_line();
          CH_CR: shadow_col = 0;
          CH_BS: begin
            // step back, wrapping to the end of the previous row; hold at top-left
            if (shadow_col > 0) begin
              shadow_col--;
            end else if (shadow_row > 0) begin
              shadow_row--;
              shadow_col = COLS - 1;
            end
            shadow_cells[shadow_row * COLS + shadow_col] = cell_word(CH_SPACE, w.fg_color);
          end
          CH_TAB: begin
            shadow_col = shadow_col + TAB - (shadow_col % TAB);
            if (shadow_col >= COLS) next_line();
          end
          default: begin
            shadow_cells[shadow_row * COLS + shadow_col] = cell_word(w.char_code, w.fg_color);
            shadow_col++;
            if (shadow_col >= COLS) next_line();
          end
        endcase
      end
      OP_SET: begin
        if (w.col < COLS && w.row < ROWS) begin
          shadow_col = int'(w.col);
          shadow_row = int'(w.row);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = cell_word(CH_SPACE, WHITE_FG);
        shadow_col = 0;
        shadow_row = 0;
      end
      OP_RECOLOR: begin
        for (int i = 0; i < CELLS; i++)
          shadow_cells[i] = cell_word(shadow_cells[i][7:0], w.fg_color);
      end
      OP_READ: begin
        if (w.col < COLS && w.row < ROWS)
          {r.cell_attr, r.cell_char} = shadow_cells[w.row * COLS + w.col];
      end
      default: ;
    endcase
    r.cur_col    = 7'(shadow_col);
    r.cur_row    = 5'(shadow_row);
    r.cur_offset = 11'(shadow_row * COLS + shadow_col);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done cycle is taken at the edge that ends it
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual %h",
                 $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.cur_col !== want.cur_col)
          flag_mismatch("cur_col", want.cur_col, result.cur_col);
        if (result.cur_row !== want.cur_row)
          flag_mismatch("cur_row", want.cur_row, result.cur_row);
        if (result.cur_offset !== want.cur_offset)
          flag_mismatch("cur_offset", want.cur_offset, result.cur_offset);
        if (result.cell_char !== want.cell_char)
          flag_mismatch("cell_char", want.cell_char, result.cell_char);
        if (result.cell_attr !== want.cell_attr)
          flag_mismatch("cell_attr", want.cell_attr, result.cell_attr);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Idle length before a word: mostly none or short, a few long
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one word and hold it until the block takes it. Keep start high
  // across back-to-back words; lower it only when a gap or a drain follows.
  // Rows with a typed expectation queue that value instead of the predicted one.
  task automatic send_word(input item_t w, input int gap, input bit drain,
                           input bit fixed, input result_t want);
    result_t predicted;
    if (drain || gap > 0) start <= 1'b0;
    if (drain) begin
      do @(posedge clk); while (pending_results.size() != 0);
    end
    repeat (gap) @(posedge clk);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = console_step(w);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  // Write the background color once the block has gone quiet
  task automatic write_background(input logic [3:0] color);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
    cfg_valid <= 1'b1;
    cfg_data  <= color;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    shadow_bg = color;
  endtask

  // Random word: mostly text at random places, with reads, some whole-screen
  // sweeps, out-of-range requests and dead opcodes as noise.
  function automatic item_t random_word();
    item_t w;
    int    pick;
    int    k;
    w.opcode    = 3'($urandom_range(0, 7));
    w.char_code = 8'($urandom);
    w.fg_color  = 4'($urandom);
    w.col       = 8'($urandom);
    w.row       = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w.opcode = OP_PUT;
      k = $urandom_range(0, 9);
      if (k < 7) w.char_code = 8'($urandom_range(8'h20, 8'h7E));
      else if (k < 9) w.char_code = CONTROL_CHARS[2'($urandom_range(0, 3))];
    end else if (pick < 65) begin
      w.opcode = OP_SET;
      // favor the bottom row so newlines and wraps scroll the store
      if ($urandom_range(0, 3) != 0) begin
        w.col = 8'($urandom_range(0, COLS - 1));
        w.row = 8'(($urandom_range(0, 2) == 0) ? ROWS - 1 : $urandom_range(0, ROWS - 1));
      end
    end else if (pick < 85) begin
      w.opcode = OP_READ;
      if ($urandom_range(0, 4) != 0) begin
        w.col = 8'($urandom_range(0, COLS - 1));
        w.row = 8'($urandom_range(0, ROWS - 1));
      end
    end else if (pick < 87) begin
      w.opcode = OP_CLEAR;
    end else if (pick < 89) begin
      w.opcode = OP_RECOLOR;
    end else if (pick < 93) begin
      w.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return w;
  endfunction

  // Run random words until enough have done real work; dead opcodes and
  // ignored cursor moves do not count. Mix in stretches with no idling and
  // the odd full drain.
  task automatic random_phase(input int target);
    int    useful;
    int    quiet_left;
    int    gap;
    bit    drain;
    item_t w;
    useful     = 0;
    quiet_left = 0;
    while (useful < target) begin
      w = random_word();
      if (quiet_left > 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(20, 40);
      end
      drain = ($urandom_range(0, 149) == 0);
      send_word(w, gap, drain, 1'b0, '0);
      if (!(w.opcode > OP_READ || (w.opcode == OP_SET && (w.col >= COLS || w.row >= ROWS))))
        useful++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: command word, and a typed result where it is obvious
  // ---------------------------------------------------------------------------
  typedef struct packed {
    item_t   word;
    logic    fixed;
    result_t want;
  } script_row_t;

  script_row_t script [$];

  function automatic void add_row(logic [2:0] op, logic [7:0] ch, logic [3:0] fg,
                                  logic [7:0] c, logic [7:0] r, logic fixed, result_t want);
    script_row_t s;
    s.word  = {op, ch, fg, c, r};
    s.fixed = fixed;
    s.want  = want;
    script.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
    shadow_col = 0;
    shadow_row = 0;
    shadow_bg  = '0;

    // store is all zero after reset, in range or not
    add_row(OP_READ, 8'h00, 4'h0, 8'd0, 8'd0, 1'b1, '0);
    add_row(OP_READ, 8'hFF, 4'hF, 8'hFF, 8'hFF, 1'b1, '0);
    // last cell, then a character there wraps, scrolls, and ends up one row above the bottom
    add_row(OP_SET, 8'h00, 4'h0, 8'd79, 8'd24, 1'b1, {7'd79, 5'd24, 11'd1999, 8'h00, 8'h00});
    add_row(OP_PUT, 8'h41, 4'hF, 8'd0, 8'd0, 1'b1, {7'd0, 5'd24, 11'd1920, 8'h00, 8'h00});
    add_row(OP_READ, 8'h00, 4'h0, 8'd79, 8'd23, 1'b1,
            {7'd0, 5'd24, 11'd1920, 8'h41, 4'h0, WHITE_FG});
    // cursor moves just out of range are ignored
    add_row(OP_SET, 8'h00, 4'h0, 8'd80, 8'd0, 1'b0, '0);
    add_row(OP_SET, 8'h00, 4'h0, 8'd0, 8'd25, 1'b0, '0);
    // backspace at top-left holds the cursor but still blanks the cell
    add_row(OP_SET, 8'h00, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_PUT, CH_BS, 4'hA, 8'd0, 8'd0, 1'b0, '0);
    // extreme character codes are plain text
    add_row(OP_PUT, 8'hFF, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_PUT, 8'h00, 4'hF, 8'hFF, 8'hFF, 1'b0, '0);
    add_row(OP_PUT, CH_BS, 4'h3, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_PUT, CH_TAB, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    // tab off the end of a row turns into a newline
    add_row(OP_SET, 8'h00, 4'h0, 8'd78, 8'd3, 1'b0, '0);
    add_row(OP_PUT, CH_TAB, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    // carriage return, newline, and backspace across a row boundary
    add_row(OP_SET, 8'h00, 4'h0, 8'd10, 8'd5, 1'b0, '0);
    add_row(OP_PUT, CH_CR, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_PUT, CH_NL, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_PUT, CH_BS, 4'h7, 8'd0, 8'd0, 1'b0, '0);
    // dead opcodes only report the cursor
    add_row(OP_SPARE_LAST, 8'hFF, 4'hF, 8'hFF, 8'hFF, 1'b0, '0);
    add_row(OP_SPARE_FIRST, 8'h00, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    // recolor keeps characters, clear blanks the store and homes the cursor
    add_row(OP_RECOLOR, 8'h00, 4'h5, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_READ, 8'h00, 4'h0, 8'd0, 8'd0, 1'b0, '0);
    add_row(OP_CLEAR, 8'hFF, 4'hF, 8'd0, 8'd0, 1'b1, '0);
    add_row(OP_READ, 8'h00, 4'h0, 8'd79, 8'd24, 1'b1,
            {7'd0, 5'd0, 11'd0, CH_SPACE, 4'h0, WHITE_FG});

    // Hold reset, then wait out the clearing pass
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy !== 1'b0);

    write_background(4'h0);
    foreach (script[i])
      send_word(script[i].word, pick_gap(), 1'b0, script[i].fixed, script[i].want);

    // Sweep the background through its extremes and a middle value
    write_background(4'hF);
    random_phase(WORDS_PER_PHASE);
    write_background(4'($urandom_range(1, 14)));
    random_phase(WORDS_PER_PHASE);
    write_background(4'h0);
    random_phase(WORDS_PER_PHASE);

    // Drain: allow for one full-store sweep on the last word, then settle
    start <= 1'b0;
    for (int n = 0; n < 4 * CELLS && pending_results.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_results.size());
      errors++;
    end

    if (errors == 0) begin
      $display("text_console_cell_writer regression: pass");
    end else begin
      $display("text_console_cell_writer regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("text_console_cell_writer regression: fail");
    $finish;
  end

endmodule
